// File: design/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// when the antecedent holds, the consequent must hold in the same cycle
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// condition must never be seen
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// File: design/mcp_pkg.sv
`timescale 1ns / 1ps
package mcp_pkg;

  typedef struct packed {
    logic [31:0] spot;
    logic [31:0] strike;
    logic [31:0] rate;
    logic [31:0] vol;
    logic [31:0] mat;
    logic        kind;
  } cfg_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } item_t;

  // register indexes
  localparam logic [2:0] RegSpot   = 3'd0;
  localparam logic [2:0] RegStrike = 3'd1;
  localparam logic [2:0] RegRate   = 3'd2;
  localparam logic [2:0] RegVol    = 3'd3;
  localparam logic [2:0] RegMat    = 3'd4;
  localparam logic [2:0] RegKind   = 3'd5;

  localparam logic [31:0] SpotRst   = 32'd6553600;
  localparam logic [31:0] StrikeRst = 32'd6881280;
  localparam logic [31:0] RateRst   = 32'd13421773;
  localparam logic [31:0] VolRst    = 32'd53687091;
  localparam logic [31:0] MatRst    = 32'd16777216;
  localparam logic        KindRst   = 1'b1;

  localparam logic        KindCall  = 1'b1;

  localparam logic [33:0] XLimit    = 34'd12884901888;
  localparam logic [28:0] Log2eQ28  = 29'd387270501;
  localparam logic [29:0] Ln2Q30    = 30'd744261118;
  localparam logic [31:0] OneQ30    = 32'h4000_0000;
  localparam logic [36:0] ExpBias   = 37'd18790481920;
  localparam logic [7:0]  ShiftBase = 8'd100;
  localparam logic [40:0] ValueCap  = 41'h100_0000_0000;
  localparam logic [31:0] U32Max    = '1;
  localparam logic [55:0] AccMax    = '1;
  localparam logic [3:0]  HornerN   = 4'd10;

  // floor(2^32 / n) for the horner divisors
  function automatic logic [32:0] recip(input logic [3:0] n);
    logic [32:0] r;
    case (n)
      4'd1:    r = 33'd4294967296;
      4'd2:    r = 33'd2147483648;
      4'd3:    r = 33'd1431655765;
      4'd4:    r = 33'd1073741824;
      4'd5:    r = 33'd858993459;
      4'd6:    r = 33'd715827882;
      4'd7:    r = 33'd613566756;
      4'd8:    r = 33'd536870912;
      4'd9:    r = 33'd477218588;
      4'd10:   r = 33'd429496729;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: design/monte_carlo_european_option_pricer.sv
`timescale 1ns / 1ps
// channel   direction  transfer when             payload
// s_axis    in         tvalid & tready           tdata: normal_sample; tlast: is_last
// m_axis    out        tvalid & tready           tdata: option_value, paths_used; tuser: overflow
// apb       in/out     psel & penable & pwrite   six pricing registers at 4*index
//
// each path runs through the engine: a bit-pair square root of the maturity, a
// ten-term horner series of 2^f at three steps a term, the rest single steps; a
// path marked last adds the divider and a second exp
// a two-entry queue takes input transfers while the engine works; the result register
// lets the engine move on while a finished price waits on the output side
// reset clears sum, path count and overflow flag and loads the default registers
module monte_carlo_european_option_pricer #(
  parameter int COUNT_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] normal_sample, signed q4.12
  input  logic        s_axis_tlast,   // is_last
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [31:0] option_value, [55:32] paths_used
  output logic        m_axis_tuser,   // [0] count_overflow
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mcp_pkg::*;

  cfg_t        cfg;
  item_t       s_item, q_item;
  logic        q_valid, q_pop;
  logic [31:0] res_value;
  logic [23:0] res_paths;

  // register file; the user must write it only between pricing runs, the block does not enforce this
  mcp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign s_item.sample = s_axis_tdata;
  assign s_item.last   = s_axis_tlast;

  // front: input transfers land in the queue
  mcp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_item_i  (s_item),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  // back: path price, payoff, running sum and the discounted mean
  mcp_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_value_o (res_value),
    .m_paths_o (res_paths),
    .m_ovf_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {res_paths, res_value};
endmodule

// File: design/mcp_regs.sv
`timescale 1ns / 1ps
module mcp_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output mcp_pkg::cfg_t cfg_o
);
  import mcp_pkg::*;

  cfg_t        cfg_q;
  logic [2:0]  idx;
  logic        wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spot   <= SpotRst;
      cfg_q.strike <= StrikeRst;
      cfg_q.rate   <= RateRst;
      cfg_q.vol    <= VolRst;
      cfg_q.mat    <= MatRst;
      cfg_q.kind   <= KindRst;
    end else if (wr) begin
      case (idx)
        RegSpot:   cfg_q.spot   <= pwdata;
        RegStrike: cfg_q.strike <= pwdata;
        RegRate:   cfg_q.rate   <= pwdata;
        RegVol:    cfg_q.vol    <= pwdata;
        RegMat:    cfg_q.mat    <= pwdata;
        RegKind:   cfg_q.kind   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegSpot:   prdata = cfg_q.spot;
      RegStrike: prdata = cfg_q.strike;
      RegRate:   prdata = cfg_q.rate;
      RegVol:    prdata = cfg_q.vol;
      RegMat:    prdata = cfg_q.mat;
      RegKind:   prdata = {31'd0, cfg_q.kind};
      default:   prdata = '0;
    endcase
  end
endmodule

// File: design/mcp_front.sv
`timescale 1ns / 1ps
module mcp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  input  mcp_pkg::item_t s_item_i,
  output logic           q_valid_o,
  output mcp_pkg::item_t q_item_o,
  input  logic           q_pop_i
);
  import mcp_pkg::*;

  // two-entry queue between input side and the path engine
  item_t      mem_q [2];
  logic [1:0] cnt_q;
  logic       wr_q, rd_q;
  logic       push, pop;

  assign s_ready_o = (cnt_q != 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = mem_q[rd_q];
  assign push      = s_valid_i && s_ready_o;
  assign pop       = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= s_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end
endmodule

// File: design/mcp_div.sv
`timescale 1ns / 1ps
module mcp_div #(
  parameter int NW = 56,
  parameter int DW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);
  localparam int CW = $clog2(NW + 1);

  // restoring division, one quotient bit a cycle
  logic [NW-1:0] quo_q;
  logic [DW-1:0] den_q;
  logic [DW:0]   rem_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_q[DW-1:0], quo_q[NW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        quo_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        cnt_q  <= CW'(NW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        quo_q <= {quo_q[NW-2:0], ge};
        rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end
endmodule

// File: design/mcp_back.sv
`timescale 1ns / 1ps
module mcp_back #(
  parameter int COUNT_BITS = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mcp_pkg::cfg_t  cfg_i,
  input  logic           q_valid_i,
  input  mcp_pkg::item_t q_item_i,
  output logic           q_pop_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output logic [31:0]    m_value_o,
  output logic [23:0]    m_paths_o,
  output logic           m_ovf_o
);
  import mcp_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [4:0] {
    S_IDLE, S_SQRT, S_HS2, S_DRIFT, S_DT1, S_DT2, S_DT3, S_X,
    E_YM, E_U, E_T, E_HM, E_HD, E_HC, E_V, E_SH,
    S_PAY, S_ACC, S_MEAN, S_DIV, S_RT, S_OUT
  } state_e;

  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  state_e                state_q;
  logic [16:0]           zmag_q;
  logic                  zneg_q, last_q;
  logic [55:0]           sq_rem_q;
  logic [56:0]           sq_res_q;
  logic [4:0]            sq_idx_q;
  logic [34:0]           hs2_q;
  logic [35:0]           dm_q, sv_q, dtb_q;
  logic                  dneg_q;
  logic [55:0]           dta_q;
  logic [40:0]           df_q;
  logic [33:0]           dt_q;
  logic [31:0]           ex_base_q;
  logic                  ex_neg_q, emit_q;
  logic [41:0]           ex_mag_q;
  logic [34:0]           ym_q;
  logic [7:0]            k_q;
  logic [27:0]           f_q;
  logic [29:0]           t_q;
  logic [31:0]           p_q;
  logic [3:0]            n_q;
  logic [30:0]           a_q, q0_q;
  logic [63:0]           v_q;
  logic [40:0]           st_q;
  logic [31:0]           pay_q, val_q;
  logic [55:0]           acc_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  ovf_q;
  logic                  out_valid_q, out_ovf_q;
  logic [31:0]           out_value_q;
  logic [23:0]           out_paths_q;

  logic                  div_start, div_busy, div_done;
  logic [55:0]           div_quo;

  logic [56:0] bitv, trial;
  logic [63:0] vv, qmp, rv, lv, rtp;
  logic [36:0] dsum, dabs;
  logic [59:0] svp, ttp;
  logic [55:0] dtap;
  logic [52:0] dfp;
  logic [47:0] dtbp;
  logic [56:0] dts;
  logic [44:0] dtr;
  logic [42:0] xa, xb, xs, xabs;
  logic [33:0] mc;
  logic [62:0] ymp;
  logic [36:0] u;
  logic [61:0] tpp;
  logic [34:0] qnp, rem_h;
  logic [30:0] qf;
  logic [7:0]  rs, ls;
  logic [40:0] res, payw;
  logic [56:0] accs;
  logic [31:0] rmag, mean;
  logic        rneg, out_free;

  assign q_pop_o   = (state_q == S_IDLE) && q_valid_i;
  assign div_start = (state_q == S_MEAN) && (cnt_q != '0);
  assign out_free  = !out_valid_q || m_ready_i;
  assign m_valid_o = out_valid_q;
  assign m_value_o = out_value_q;
  assign m_paths_o = out_paths_q;
  assign m_ovf_o   = out_ovf_q;

  mcp_div #(.NW(56), .DW(COUNT_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_q),
    .den_i   (cnt_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    rneg  = cfg_i.rate[31];
    rmag  = rneg ? (~cfg_i.rate + 32'd1) : cfg_i.rate;
    // square root step
    bitv  = 57'(1) << {sq_idx_q, 1'b0};
    trial = sq_res_q + bitv;
    // drift and diffusion terms
    vv    = 64'(cfg_i.vol) * 64'(cfg_i.vol);
    dsum  = {{5{cfg_i.rate[31]}}, cfg_i.rate} - {2'b00, hs2_q};
    dabs  = dsum[36] ? (~dsum + 37'd1) : dsum;
    svp   = 60'(cfg_i.vol) * 60'(sq_res_q[27:0]);
    dtap  = 56'(dm_q) * 56'(cfg_i.mat[31:12]);
    dfp   = 53'(sv_q) * 53'(zmag_q);
    dtbp  = 48'(dm_q) * 48'(cfg_i.mat[11:0]);
    dts   = 57'(dta_q) + 57'(dtb_q);
    dtr   = dts[56:12];
    xa    = dneg_q ? (~{9'd0, dt_q} + 43'd1) : {9'd0, dt_q};
    xb    = zneg_q ? (~{2'd0, df_q} + 43'd1) : {2'd0, df_q};
    xs    = xa + xb;
    xabs  = xs[42] ? (~xs + 43'd1) : xs;
    // exponential
    mc    = (ex_mag_q > 42'(XLimit)) ? XLimit : ex_mag_q[33:0];
    ymp   = 63'(mc) * 63'(Log2eQ28);
    u     = ex_neg_q ? (ExpBias - 37'(ym_q)) : (ExpBias + 37'(ym_q));
    ttp   = 60'({f_q, 2'b00}) * 60'(Ln2Q30);
    tpp   = 62'(t_q) * 62'(p_q);
    qmp   = 64'(a_q) * 64'(recip(n_q));
    qnp   = 35'(q0_q) * 35'(n_q);
    rem_h = {4'd0, a_q} - qnp;
    qf    = (rem_h >= 35'(n_q)) ? (q0_q + 31'd1) : q0_q;
    rs    = ShiftBase - k_q;
    ls    = k_q - ShiftBase;
    rv    = v_q >> rs[5:0];
    lv    = v_q << ls[5:0];
    if (v_q == '0) begin
      res = '0;
    end else if (k_q <= ShiftBase) begin
      if (rs >= 8'd64)                res = '0;
      else if (rv > 64'(ValueCap))    res = ValueCap;
      else                            res = rv[40:0];
    end else begin
      if (ls >= 8'd40 || v_q > (64'(ValueCap) >> ls[5:0])) res = ValueCap;
      else                                                  res = lv[40:0];
    end
    // payoff and sum
    if (cfg_i.kind == KindCall)
      payw = (st_q > 41'(cfg_i.strike)) ? (st_q - 41'(cfg_i.strike)) : '0;
    else
      payw = (41'(cfg_i.strike) > st_q) ? (41'(cfg_i.strike) - st_q) : '0;
    accs  = 57'(acc_q) + 57'(pay_q);
    mean  = (div_quo > 56'(U32Max)) ? U32Max : div_quo[31:0];
    rtp   = 64'(rmag) * 64'(cfg_i.mat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      zmag_q      <= '0;
      zneg_q      <= 1'b0;
      last_q      <= 1'b0;
      sq_rem_q    <= '0;
      sq_res_q    <= '0;
      sq_idx_q    <= '0;
      hs2_q       <= '0;
      dm_q        <= '0;
      dneg_q      <= 1'b0;
      sv_q        <= '0;
      dta_q       <= '0;
      dtb_q       <= '0;
      df_q        <= '0;
      dt_q        <= '0;
      ex_base_q   <= '0;
      ex_neg_q    <= 1'b0;
      ex_mag_q    <= '0;
      emit_q      <= 1'b0;
      ym_q        <= '0;
      k_q         <= '0;
      f_q         <= '0;
      t_q         <= '0;
      p_q         <= '0;
      n_q         <= '0;
      a_q         <= '0;
      q0_q        <= '0;
      v_q         <= '0;
      st_q        <= '0;
      pay_q       <= '0;
      val_q       <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_paths_q <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (m_ready_i)               out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            zneg_q   <= q_item_i.sample[15];
            zmag_q   <= q_item_i.sample[15] ? (17'h10000 - {1'b0, q_item_i.sample})
                                            : {1'b0, q_item_i.sample};
            last_q   <= q_item_i.last;
            sq_rem_q <= {cfg_i.mat, 24'd0};
            sq_res_q <= '0;
            sq_idx_q <= 5'd27;
            state_q  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if ({1'b0, sq_rem_q} >= trial) begin
            sq_rem_q <= sq_rem_q - trial[55:0];
            sq_res_q <= (sq_res_q >> 1) + bitv;
          end else begin
            sq_res_q <= sq_res_q >> 1;
          end
          sq_idx_q <= sq_idx_q - 5'd1;
          if (sq_idx_q == 5'd0) state_q <= S_HS2;
        end
        S_HS2: begin
          hs2_q   <= vv[63:29];
          state_q <= S_DRIFT;
        end
        S_DRIFT: begin
          dneg_q  <= dsum[36];
          dm_q    <= dabs[35:0];
          sv_q    <= svp[59:24];
          state_q <= S_DT1;
        end
        S_DT1: begin
          dta_q   <= dtap;
          df_q    <= dfp[52:12];
          state_q <= S_DT2;
        end
        S_DT2: begin
          dtb_q   <= dtbp[47:12];
          state_q <= S_DT3;
        end
        S_DT3: begin
          dt_q    <= (dtr > 45'(XLimit)) ? XLimit : dtr[33:0];
          state_q <= S_X;
        end
        S_X: begin
          ex_base_q <= cfg_i.spot;
          ex_neg_q  <= xs[42];
          ex_mag_q  <= xabs[41:0];
          emit_q    <= 1'b0;
          state_q   <= E_YM;
        end
        E_YM: begin
          ym_q    <= ymp[62:28];
          state_q <= E_U;
        end
        E_U: begin
          k_q     <= u[35:28];
          f_q     <= u[27:0];
          state_q <= E_T;
        end
        E_T: begin
          t_q     <= ttp[59:30];
          p_q     <= OneQ30;
          n_q     <= HornerN;
          state_q <= E_HM;
        end
        E_HM: begin
          a_q     <= tpp[60:30];
          state_q <= E_HD;
        end
        E_HD: begin
          q0_q    <= qmp[62:32];
          state_q <= E_HC;
        end
        E_HC: begin
          p_q     <= OneQ30 + 32'(qf);
          n_q     <= n_q - 4'd1;
          state_q <= (n_q == 4'd1) ? E_V : E_HM;
        end
        E_V: begin
          v_q     <= 64'(ex_base_q) * 64'(p_q);
          state_q <= E_SH;
        end
        E_SH: begin
          if (emit_q) begin
            val_q   <= (res > 41'(U32Max)) ? U32Max : res[31:0];
            state_q <= S_OUT;
          end else begin
            st_q    <= res;
            state_q <= S_PAY;
          end
        end
        S_PAY: begin
          pay_q   <= (payw > 41'(U32Max)) ? U32Max : payw[31:0];
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (cnt_q == CntMax) begin
            ovf_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 1'b1;
            acc_q <= accs[56] ? AccMax : accs[55:0];
          end
          state_q <= last_q ? S_MEAN : S_IDLE;
        end
        S_MEAN: begin
          if (cnt_q == '0) begin
            val_q   <= '0;
            state_q <= S_OUT;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) state_q <= S_RT;
        end
        S_RT: begin
          ex_base_q <= mean;
          ex_mag_q  <= rtp[63:24] > 40'(XLimit) ? 42'(XLimit) : 42'(rtp[63:24]);
          ex_neg_q  <= (rtp[63:24] != '0) && !rneg;
          emit_q    <= 1'b1;
          state_q   <= E_YM;
        end
        S_OUT: begin
          if (out_free) begin
            out_value_q <= val_q;
            out_paths_q <= 24'(cnt_q);
            out_ovf_q   <= ovf_q;
            acc_q       <= '0;
            cnt_q       <= '0;
            ovf_q       <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_ovf_full, clk_i, rst_ni, ovf_q, cnt_q == CntMax, "overflow flag without full counter")
  `ASSERT_IMPL(a_div_wait, clk_i, rst_ni, div_busy, state_q == S_DIV, "divider busy outside wait state")
  `ASSERT_NEVER(a_horner_n, clk_i, rst_ni, (state_q == E_HM) && (n_q == 4'd0 || n_q > HornerN), "horner index out of range")
endmodule
